### sv/gcp_pkg.sv
// shared types and constants of the binary gltf container parser
`default_nettype none

package gcp_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;

    localparam logic [WORD_W-1:0] MAGIC_GLTF   = 32'h4654_6C67;
    localparam logic [WORD_W-1:0] CHUNK_JSON   = 32'h4E4F_534A;
    localparam logic [WORD_W-1:0] CHUNK_BIN    = 32'h004E_4942;
    localparam logic [WORD_W-1:0] HEADER_BYTES = 32'd12;
    localparam logic [WORD_W-1:0] POS_MAGIC    = 32'd3;
    localparam logic [WORD_W-1:0] POS_VERSION  = 32'd7;
    localparam logic [WORD_W-1:0] POS_TOTAL    = HEADER_BYTES - 32'd1;
    localparam logic [WORD_W-1:0] VERSION_REQ  = 32'd2;
    localparam logic [WORD_W-1:0] VERSION_END  = 32'd8;
    localparam logic [WORD_W-1:0] CHUNK_HDR_BYTES = 32'd8;
    localparam logic [WORD_W-1:0] LEN_DONE_LEFT   = 32'd4;
    localparam logic [WORD_W-1:0] POS_MAX      = 32'hFFFF_FFFF;
    localparam logic [1:0]        ALIGN_MASK   = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_CHUNK_HDR = 3'd1,
        PH_PAYLOAD   = 3'd2,
        PH_PAD       = 3'd3,
        PH_DONE      = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_VERSION  = 3'd3,
        ST_OVERRUN  = 3'd4,
        ST_NO_JSON  = 3'd5
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] file_version;
        logic [WORD_W-1:0] json_offset;
        logic [WORD_W-1:0] json_length;
        logic              bin_found;
        logic [WORD_W-1:0] bin_offset;
        logic [WORD_W-1:0] bin_length;
    } result_t;

endpackage

`default_nettype wire

### sv/gcp_core.sv
// parse state of the container: header check, chunk walk and final status
`default_nettype none

module gcp_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step,
    input  wire logic [gcp_pkg::BYTE_W-1:0] byte_value,
    input  wire logic                      is_last,
    output gcp_pkg::result_t               res
);

    logic [gcp_pkg::WORD_W-1:0] pos_reg, pos_next;
    logic [gcp_pkg::WORD_W-1:0] wa_reg, wa_next;
    gcp_pkg::phase_t            phase_reg, phase_next;
    logic [gcp_pkg::WORD_W-1:0] total_reg, total_next;
    logic [gcp_pkg::WORD_W-1:0] len_reg, len_next;
    logic [gcp_pkg::WORD_W-1:0] left_reg, left_next;
    logic [gcp_pkg::WORD_W-1:0] version_reg, version_next;
    logic                       json_seen_reg, json_seen_next;
    logic [gcp_pkg::WORD_W-1:0] json_start_reg, json_start_next;
    logic [gcp_pkg::WORD_W-1:0] json_size_reg, json_size_next;
    logic                       bin_seen_reg, bin_seen_next;
    logic [gcp_pkg::WORD_W-1:0] bin_start_reg, bin_start_next;
    logic [gcp_pkg::WORD_W-1:0] bin_size_reg, bin_size_next;
    gcp_pkg::status_t           err_reg, err_next;

    logic                       parse_en;
    logic [gcp_pkg::WORD_W-1:0] wa_shift;
    logic [gcp_pkg::WORD_W-1:0] pos_inc;
    logic [gcp_pkg::WORD_W-1:0] left_dec;
    logic [1:0]                 align;
    gcp_pkg::phase_t            after_phase;
    logic [gcp_pkg::WORD_W-1:0] after_left;
    gcp_pkg::status_t           status;
    logic                       report;

    assign parse_en = (pos_reg != gcp_pkg::POS_MAX);
    assign wa_shift = {byte_value, wa_reg[gcp_pkg::WORD_W-1:gcp_pkg::BYTE_W]};
    assign pos_inc  = pos_reg + 32'd1;
    assign left_dec = left_reg - 32'd1;
    assign align    = pos_inc[1:0] & gcp_pkg::ALIGN_MASK;

    // next aligned start after a payload ends at this byte
    always_comb begin
        if (align != 2'd0) begin
            after_phase = gcp_pkg::PH_PAD;
            after_left  = 32'(2'(2'd0 - align));
        end else begin
            after_phase = gcp_pkg::PH_CHUNK_HDR;
            after_left  = gcp_pkg::CHUNK_HDR_BYTES;
        end
    end

    always_comb begin
        pos_next        = pos_reg;
        wa_next         = wa_reg;
        phase_next      = phase_reg;
        total_next      = total_reg;
        len_next        = len_reg;
        left_next       = left_reg;
        version_next    = version_reg;
        json_seen_next  = json_seen_reg;
        json_start_next = json_start_reg;
        json_size_next  = json_size_reg;
        bin_seen_next   = bin_seen_reg;
        bin_start_next  = bin_start_reg;
        bin_size_next   = bin_size_reg;
        err_next        = err_reg;
        if (parse_en) begin
            wa_next  = wa_shift;
            pos_next = pos_inc;
            unique case (phase_reg)
                gcp_pkg::PH_HEADER: begin
                    priority if (pos_reg == gcp_pkg::POS_MAGIC) begin
                        if (wa_shift != gcp_pkg::MAGIC_GLTF) err_next = gcp_pkg::ST_MAGIC;
                    end else if (pos_reg == gcp_pkg::POS_VERSION) begin
                        version_next = wa_shift;
                        if (err_reg == gcp_pkg::ST_OK && wa_shift != gcp_pkg::VERSION_REQ)
                            err_next = gcp_pkg::ST_VERSION;
                    end else if (pos_reg == gcp_pkg::POS_TOTAL) begin
                        total_next = wa_shift;
                        phase_next = gcp_pkg::PH_CHUNK_HDR;
                        left_next  = gcp_pkg::CHUNK_HDR_BYTES;
                    end else begin
                    end
                end
                gcp_pkg::PH_CHUNK_HDR: begin
                    left_next = left_dec;
                    priority if (left_dec == gcp_pkg::LEN_DONE_LEFT) begin
                        len_next = wa_shift;
                    end else if (left_dec == 32'd0) begin
                        priority if (pos_inc > total_reg) begin
                            // header ends past the declared total: walk stops quietly
                            phase_next = gcp_pkg::PH_DONE;
                        end else if (len_reg > total_reg - pos_inc) begin
                            if (err_reg == gcp_pkg::ST_OK) err_next = gcp_pkg::ST_OVERRUN;
                            phase_next = gcp_pkg::PH_DONE;
                        end else begin
                            if (wa_shift == gcp_pkg::CHUNK_JSON && !json_seen_reg) begin
                                json_seen_next  = 1'b1;
                                json_start_next = pos_inc;
                                json_size_next  = len_reg;
                            end else if (wa_shift == gcp_pkg::CHUNK_BIN && !bin_seen_reg) begin
                                bin_seen_next  = 1'b1;
                                bin_start_next = pos_inc;
                                bin_size_next  = len_reg;
                            end
                            if (len_reg == 32'd0) begin
                                phase_next = after_phase;
                                left_next  = after_left;
                            end else begin
                                phase_next = gcp_pkg::PH_PAYLOAD;
                                left_next  = len_reg;
                            end
                        end
                    end else begin
                    end
                end
                gcp_pkg::PH_PAYLOAD: begin
                    left_next = left_dec;
                    if (left_dec == 32'd0) begin
                        phase_next = after_phase;
                        left_next  = after_left;
                    end
                end
                gcp_pkg::PH_PAD: begin
                    left_next = left_dec;
                    if (left_dec == 32'd0) begin
                        phase_next = gcp_pkg::PH_CHUNK_HDR;
                        left_next  = gcp_pkg::CHUNK_HDR_BYTES;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // final status: a file shorter than the header reports short, otherwise the first error in file order wins
    always_comb begin
        priority if (pos_next < gcp_pkg::HEADER_BYTES) begin
            status = gcp_pkg::ST_SHORT;
        end else if (err_next == gcp_pkg::ST_MAGIC || err_next == gcp_pkg::ST_VERSION
                     || err_next == gcp_pkg::ST_OVERRUN) begin
            status = err_next;
        end else if (phase_next == gcp_pkg::PH_PAYLOAD && left_next != 32'd0) begin
            status = gcp_pkg::ST_OVERRUN;
        end else if (!json_seen_next) begin
            status = gcp_pkg::ST_NO_JSON;
        end else begin
            status = gcp_pkg::ST_OK;
        end
    end

    assign report = (status == gcp_pkg::ST_OK) || (status == gcp_pkg::ST_NO_JSON);

    always_comb begin
        res.status       = status;
        res.file_version = (pos_next >= gcp_pkg::VERSION_END) ? version_next : '0;
        res.json_offset  = report ? json_start_next : '0;
        res.json_length  = report ? json_size_next : '0;
        res.bin_found    = report ? bin_seen_next : 1'b0;
        res.bin_offset   = report ? bin_start_next : '0;
        res.bin_length   = report ? bin_size_next : '0;
    end

    // the final byte returns everything to the reset state
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && is_last)) begin
            pos_reg        <= '0;
            wa_reg         <= '0;
            phase_reg      <= gcp_pkg::PH_HEADER;
            total_reg      <= '0;
            len_reg        <= '0;
            left_reg       <= '0;
            version_reg    <= '0;
            json_seen_reg  <= 1'b0;
            json_start_reg <= '0;
            json_size_reg  <= '0;
            bin_seen_reg   <= 1'b0;
            bin_start_reg  <= '0;
            bin_size_reg   <= '0;
            err_reg        <= gcp_pkg::ST_OK;
        end else if (step) begin
            pos_reg        <= pos_next;
            wa_reg         <= wa_next;
            phase_reg      <= phase_next;
            total_reg      <= total_next;
            len_reg        <= len_next;
            left_reg       <= left_next;
            version_reg    <= version_next;
            json_seen_reg  <= json_seen_next;
            json_start_reg <= json_start_next;
            json_size_reg  <= json_size_next;
            bin_seen_reg   <= bin_seen_next;
            bin_start_reg  <= bin_start_next;
            bin_size_reg   <= bin_size_next;
            err_reg        <= err_next;
        end
    end

    a_hdr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == gcp_pkg::PH_CHUNK_HDR |-> (left_reg != 32'd0 && left_reg <= 32'd8))
        else $error("chunk header countdown out of range");

    a_pad_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == gcp_pkg::PH_PAD |-> (left_reg != 32'd0 && left_reg <= 32'd3))
        else $error("padding countdown out of range");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != gcp_pkg::ST_SHORT && err_reg != gcp_pkg::ST_NO_JSON)
        else $error("latched error holds a final-only code");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && is_last |=> pos_reg == '0 && phase_reg == gcp_pkg::PH_HEADER)
        else $error("final word did not restart the parser");

    a_json_after_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        json_seen_reg |-> json_start_reg >= 32'd20)
        else $error("json payload recorded inside the file header");

endmodule

`default_nettype wire

### sv/glb_container_chunk_parser_unit.sv
// top level of the binary gltf container parser
//
// Input channel: one file byte per word on s_tdata, s_tlast on the final byte.
// Result channel: one word per file, issued for the final byte only; status and
// bin_found travel on m_tuser, the offsets, lengths and version on m_tdata.
// A byte accepted into the input register is parsed from there into the parse
// state; for the final byte the result register is loaded at that same edge,
// so the result is valid on the master side once the final byte is parsed.
// Throughput: one byte per cycle while no final byte is held back; every byte
// needs only counter and compare updates.
// A stalled receiver only holds back a final byte while the previous result
// is still waiting; meanwhile the input register stays full and takes no byte.
// Reset (aresetn low, synchronous) empties both registers and returns the parser
// to the start of a file; after each final byte the parser also restarts, so
// the next byte begins a new file.
`default_nettype none

module glb_container_chunk_parser_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // byte_value
    input  wire logic         s_tlast,   // is_last
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // file_version, json_offset, json_length, bin_offset, bin_length
    output logic [159:0]      m_tdata,
    output logic [3:0]        m_tuser    // status, bin_found
);

    logic                          in_valid_reg;
    logic [gcp_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          in_last_reg;
    logic                          out_valid_reg;
    gcp_pkg::result_t              out_reg;
    gcp_pkg::result_t              core_res;
    logic                          core_step;
    logic                          s_take;
    logic                          m_take;

    assign m_take    = out_valid_reg && m_tready;
    // a final byte waits until the result register is free
    assign core_step = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || core_step;
    assign s_take    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (core_step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    gcp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (core_step),
        .byte_value (in_byte_reg),
        .is_last    (in_last_reg),
        .res        (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (core_step && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_step && in_last_reg) begin
            out_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.bin_length, out_reg.bin_offset, out_reg.json_length,
                       out_reg.json_offset, out_reg.file_version};
    assign m_tuser  = {out_reg.bin_found, out_reg.status};

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_last_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("final word dropped while result register was full");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(core_step && in_last_reg))
        else $error("result issued without a final word");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
